// ===== hdl/thac_pkg.sv =====
// Package with the shared constants, types and helpers of the admission controller.
`timescale 1ns / 1ps

package thac_pkg;

    // Lease store depth and index width.
    localparam int DEPTH = 1024;
    localparam int IDX_W = $clog2(DEPTH);

    // Field widths.
    localparam int SIZE_W = 16;
    localparam int OCC_W  = 20;
    localparam int HOLD_W = 10;
    localparam int TICK_W = 32;

    // Configuration port geometry.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Register indexes.
    localparam logic REG_CAPACITY  = 1'b0;
    localparam logic REG_HOLD_TIME = 1'b1;

    typedef logic [IDX_W-1:0] t_idx;

    // One stored lease.
    typedef struct packed {
        logic [TICK_W-1:0] expiry;
        logic [SIZE_W-1:0] size;
    } t_lease;

    // Configuration seen by the core.
    typedef struct packed {
        logic [OCC_W-1:0]  capacity;
        logic [HOLD_W-1:0] hold_time;
    } t_cfg;

    // Result of one tick.
    typedef struct packed {
        logic             admitted;
        logic [OCC_W-1:0] occupancy;
    } t_result;

    // Ring index increment that wraps at DEPTH.
    function automatic t_idx next_idx(input t_idx i);
        t_idx r;
        if (i == t_idx'(DEPTH - 1)) begin
            r = '0;
        end else begin
            r = i + t_idx'(1);
        end
        return r;
    endfunction

endpackage

// ===== hdl/thac_ifs.sv =====
// Valid/ready channel interfaces for group requests and tick results.
`timescale 1ns / 1ps

interface thac_grp_if
    import thac_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [SIZE_W-1:0] group_size;

    modport source (output valid, output group_size, input ready);
    modport sink   (input valid, input group_size, output ready);
endinterface

interface thac_res_if
    import thac_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             admitted;
    logic [OCC_W-1:0] occupancy;

    modport source (output valid, output admitted, output occupancy, input ready);
    modport sink   (input valid, input admitted, input occupancy, output ready);
endinterface

// ===== hdl/thac_lease_core.sv =====
// Lease FIFO in a synchronous memory with the per-tick release and admission update.
`timescale 1ns / 1ps

module thac_lease_core
    import thac_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [SIZE_W-1:0] i_group_size,
    input  t_cfg              i_cfg,
    output t_result           o_result
);

    // Lease memory and its registered read port.
    t_lease r_lease_mem [DEPTH];
    t_lease r_head_ent;

    // Ring pointers, occupancy and tick counter.
    t_idx              r_head;
    t_idx              r_tail;
    logic [OCC_W-1:0]  r_occ;
    logic [TICK_W-1:0] r_tick;

    t_idx              n_head;
    t_idx              n_tail;
    logic [OCC_W-1:0]  n_occ;
    logic [TICK_W-1:0] n_tick;

    logic              release_hd;
    logic [OCC_W-1:0]  occ_rel;
    logic [OCC_W-1:0]  size_ext;
    logic              fits;
    logic              room;
    logic              admit;
    t_lease            wr_lease;

    // Release the head lease if it expires now, then try to admit the new group.
    always_comb begin
        size_ext   = OCC_W'(i_group_size);
        release_hd = i_accept && (r_head != r_tail) && (r_head_ent.expiry == r_tick);
        occ_rel    = r_occ;
        n_head     = r_head;
        if (release_hd) begin
            occ_rel = (r_occ >= OCC_W'(r_head_ent.size)) ?
                      r_occ - OCC_W'(r_head_ent.size) : '0;
            n_head  = next_idx(r_head);
        end
        fits  = ({1'b0, occ_rel} + {1'b0, size_ext}) <= {1'b0, i_cfg.capacity};
        room  = next_idx(r_tail) != n_head;
        admit = i_accept && fits && room;

        wr_lease.expiry = r_tick + TICK_W'(i_cfg.hold_time);
        wr_lease.size   = i_group_size;

        n_occ  = admit ? occ_rel + size_ext : occ_rel;
        n_tail = admit ? next_idx(r_tail) : r_tail;
        n_tick = i_accept ? r_tick + TICK_W'(1) : r_tick;

        o_result.admitted  = admit;
        o_result.occupancy = n_occ;
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_occ  <= '0;
            r_tick <= '0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_occ  <= n_occ;
            r_tick <= n_tick;
        end
    end

    // Memory write of the admitted lease.
    always_ff @(posedge i_clk) begin
        if (admit) begin
            r_lease_mem[r_tail] <= wr_lease;
        end
    end

    // Prefetch the next head entry, forwarding a same-cycle write to that slot.
    always_ff @(posedge i_clk) begin
        if (admit && (r_tail == n_head)) begin
            r_head_ent <= wr_lease;
        end else begin
            r_head_ent <= r_lease_mem[n_head];
        end
    end

endmodule

// ===== hdl/timed_hold_admission_control_unit.sv =====
// Top level of the timed-hold admission controller: APB registers, core and output buffer.
`timescale 1ns / 1ps

// The unit takes one group request per clock cycle while the skid stage of its output
// buffer is empty, and returns one result per request: an admitted flag and the
// occupancy after that tick's release and admission. Each request is a tick; the head
// lease is released when its expiry equals the tick count, and the group is admitted
// when it fits under the capacity and the lease ring has room. Leases live in a
// single-port-write, single-read memory of DEPTH entries whose read port always
// fetches the slot that will be the head on the next cycle, so the release check need
// not wait for a memory read; each result is registered in a two-entry output buffer
// that keeps requests flowing while the consumer stalls; requests stop only when both
// entries are full. Registers capacity (0x0) and hold_time (0x4) are written through
// the APB port; the user must write them only while no request is in flight, as the
// block itself does not enforce it; hold_time must lie between 1 and DEPTH - 1 for
// expiring leases to be released on time.
module timed_hold_admission_control_unit
    import thac_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    thac_grp_if.sink           i_grp,
    thac_res_if.source         o_res
);

    t_cfg    r_cfg;
    t_result core_res;
    logic    accept;

    // Output buffer: main stage and skid stage.
    logic    r_out_valid;
    t_result r_out;
    logic    r_skid_valid;
    t_result r_skid;
    logic    out_pop;

    // Configuration writes.
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.capacity  <= '0;
            r_cfg.hold_time <= HOLD_W'(1);
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[2])
                REG_CAPACITY:  r_cfg.capacity  <= pwdata[OCC_W-1:0];
                REG_HOLD_TIME: r_cfg.hold_time <= pwdata[HOLD_W-1:0];
                default:       r_cfg <= r_cfg;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        unique case (paddr[2])
            REG_CAPACITY:  prdata = PDATA_W'(r_cfg.capacity);
            REG_HOLD_TIME: prdata = PDATA_W'(r_cfg.hold_time);
            default:       prdata = '0;
        endcase
    end

    // Input handshake.
    assign i_grp.ready = !r_skid_valid;
    assign accept      = i_grp.valid && i_grp.ready;

    thac_lease_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_group_size (i_grp.group_size),
        .i_cfg        (r_cfg),
        .o_result     (core_res)
    );

    // Output buffer control.
    assign out_pop = r_out_valid && o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (accept) begin
            if (r_out_valid && !out_pop) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (out_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output buffer data.
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_pop) begin
                r_out <= r_skid;
            end
        end else if (accept) begin
            if (r_out_valid && !out_pop) begin
                r_skid <= core_res;
            end else begin
                r_out <= core_res;
            end
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.admitted  = r_out.admitted;
    assign o_res.occupancy = r_out.occupancy;

endmodule
